// ===== hw/rtl/psac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psac_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MIN_PACKET_BYTES = 5;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned ACC_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_HEADER_END = COUNT_W'(HEADER_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MIN_PACKET_BYTES);

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    acc_t checksum;
    logic matches_res;
    logic status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/packet_shift_add_checksum_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// in       | in_valid/in_ready, in_data_byte,        | sink
//          | in_last_byte                            |
// out      | out_valid/out_ready, out_checksum,      | source
//          | out_matches_res, out_status             |
// cfg      | cfg_valid/cfg_ready, cfg_check_mode     | sink
//
// One word per cycle while in_ready is high: packet state updates in the cycle
// a word is accepted. A result is registered into the output register, or into
// the skid stage while that stays full. An output register plus a one-entry skid
// stage decouple the two sides; in_ready drops only while both hold results.
// Synchronous active-low reset clears mode, packet state and valid flags.

module packet_shift_add_checksum_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_checksum,
  output      logic        out_matches_res,
  output      logic        out_status,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_check_mode
);

  logic                 check_mode_r;
  psac_pkg::acc_t       acc_r, acc_nxt;
  psac_pkg::acc_t       hdr_r, hdr_nxt;
  psac_pkg::count_t     cnt_r, cnt_nxt;
  psac_pkg::result_t    res;
  psac_pkg::result_t    out_r, out_nxt;
  psac_pkg::result_t    skid_r, skid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic                 in_acc;
  logic                 res_valid;
  logic                 out_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign res_valid = in_acc && in_last_byte;
  assign out_take  = out_valid_r && out_ready;

  always_comb begin
    acc_t_calc: begin
      hdr_nxt = hdr_r;
      acc_nxt = acc_r;
      if (cnt_r < psac_pkg::COUNT_HEADER_END) begin
        if (check_mode_r) begin
          hdr_nxt = {hdr_r[psac_pkg::ACC_W-9:0], in_data_byte};
        end
      end else begin
        acc_nxt = {acc_r[psac_pkg::ACC_W-2:0], 1'b0}
                  + psac_pkg::ACC_W'(in_data_byte)
                  + psac_pkg::ACC_W'(acc_r[psac_pkg::ACC_W-1]);
      end
      cnt_nxt = (cnt_r < psac_pkg::COUNT_SAT) ? cnt_r + 1'b1 : cnt_r;
    end
  end

  always_comb begin
    if (cnt_nxt < psac_pkg::COUNT_SAT) begin
      res.checksum    = '0;
      res.matches_res = 1'b0;
      res.status      = 1'b1;
    end else begin
      res.checksum    = acc_nxt;
      res.matches_res = check_mode_r && (hdr_nxt == acc_nxt);
      res.status      = 1'b0;
    end
  end

  // output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_nxt) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
      acc_r        <= '0;
      hdr_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        check_mode_r <= cfg_check_mode;
      end
      if (in_acc) begin
        if (in_last_byte) begin
          acc_r <= '0;
          hdr_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          hdr_r <= hdr_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_checksum    = out_r.checksum;
  assign out_matches_res = out_r.matches_res;
  assign out_status      = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without output word");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= psac_pkg::COUNT_SAT)
    else $error("byte count beyond saturation");

  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status) |-> (out_checksum == '0 && !out_matches_res))
    else $error("short-packet word carries checksum data");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> (cnt_r == '0 && acc_r == '0 && hdr_r == '0))
    else $error("packet state not cleared after last word");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> out_valid_r)
    else $error("result word lost");

endmodule

`default_nettype wire
